// ===== rtl/http_byte_range_parser_defines.svh =====
// ----------------------------------------------------------------------------
// HTTP byte-range parser assertion macros
// Shared concurrent assertion forms, clocked on clk with arst_n reset.
// ----------------------------------------------------------------------------
`ifndef HTTP_BYTE_RANGE_PARSER_DEFINES_SVH
`define HTTP_BYTE_RANGE_PARSER_DEFINES_SVH

// same-cycle implication
`define BRP_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define BRP_ASSERT_NXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== rtl/brp_pkg.sv =====
// ----------------------------------------------------------------------------
// HTTP byte-range parser package
// Status codes, character constants, field widths and the stage snapshot.
// ----------------------------------------------------------------------------
package brp_pkg;

	localparam int CHAR_W  = 8;
	localparam int FIELD_W = 63;
	localparam int RANGE_W = 64;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_BAD   = 2'd1,
		ST_UNSAT = 2'd2,
		ST_LARGE = 2'd3
	} brp_status_t;

	localparam logic [2:0]        PFX_LEN   = 3'd6;
	localparam logic [CHAR_W-1:0] CH_HYPHEN = 8'h2d;
	localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2c;
	localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;

	// "bytes="
	function automatic logic [CHAR_W-1:0] lead_char(input logic [2:0] pos);
		logic [CHAR_W-1:0] c;
		case (pos)
			3'd0:    c = 8'h62;
			3'd1:    c = 8'h79;
			3'd2:    c = 8'h74;
			3'd3:    c = 8'h65;
			3'd4:    c = 8'h73;
			3'd5:    c = 8'h3d;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	typedef struct packed {
		logic               empty;
		brp_status_t        err;
		logic               pfx_ok;
		logic               hyphen;
		logic               first_any;
		logic               first_long;
		logic               first_ovf;
		logic [FIELD_W-1:0] first_num;
		logic               last_any;
		logic               last_long;
		logic               last_ovf;
		logic [FIELD_W-1:0] last_num;
		logic [FIELD_W-1:0] size;
	} brp_snap_t;

endpackage

// ===== rtl/brp_in_if.sv =====
// ----------------------------------------------------------------------------
// HTTP byte-range parser input channel
// Valid/ready channel carrying one field character per transaction.
// ----------------------------------------------------------------------------
interface brp_in_if;
	import brp_pkg::*;

	logic               valid;
	logic               ready;
	logic [CHAR_W-1:0]  char_code;
	logic               last_char;
	logic               empty_field;
	logic [FIELD_W-1:0] file_size;

	modport source(output valid, output char_code, output last_char,
		output empty_field, output file_size, input ready);
	modport sink(input valid, input char_code, input last_char,
		input empty_field, input file_size, output ready);
endinterface

// ===== rtl/brp_out_if.sv =====
// ----------------------------------------------------------------------------
// HTTP byte-range parser result channel
// Valid/ready channel carrying status and inclusive byte range.
// ----------------------------------------------------------------------------
interface brp_out_if;
	import brp_pkg::*;

	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [FIELD_W-1:0] range_low;
	logic [RANGE_W-1:0] range_high;

	modport source(output valid, output status, output range_low,
		output range_high, input ready);
	modport sink(input valid, input status, input range_low,
		input range_high, output ready);
endinterface

// ===== rtl/brp_parse.sv =====
// ----------------------------------------------------------------------------
// HTTP byte-range parser character stage
// Input register, per-character scan state and end-of-field snapshot.
// ----------------------------------------------------------------------------
module brp_parse #(
	parameter int LENGTH_LIMIT = 200,
	parameter int VALUE_BITS   = 63
) (
	input  logic              clk,
	input  logic              arst_n,
	brp_in_if.sink            req,
	output brp_pkg::brp_snap_t snap,
	output logic              snap_valid,
	input  logic              snap_ready
);
	import brp_pkg::*;

	localparam int CNT_W = $clog2(LENGTH_LIMIT + 1);
	localparam int ACC_W = VALUE_BITS + 4;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(LENGTH_LIMIT);

	logic               v_s1;
	logic [CHAR_W-1:0]  char_s1;
	logic               last_s1;
	logic               empty_s1;
	logic [FIELD_W-1:0] size_s1;

	logic [2:0]            pfx_q, pfx_n;
	brp_status_t           err_q, err_n;
	logic                  hyphen_q, hyphen_n;
	logic                  after_q, after_n;
	logic [CNT_W-1:0]      fcnt_q, fcnt_n, lcnt_q, lcnt_n;
	logic [VALUE_BITS-1:0] fnum_q, fnum_n, lnum_q, lnum_n;
	logic                  fovf_q, fovf_n, lovf_q, lovf_n;

	brp_snap_t snap_s2, snap_n;
	logic      v_s2;

	logic                  s2_free, res_s1, adv_s1, is_digit, acc_ovf;
	logic [3:0]            digit;
	logic [VALUE_BITS-1:0] acc_cur;
	logic [ACC_W-1:0]      acc_sum;

	assign s2_free   = !v_s2 || snap_ready;
	assign res_s1    = last_s1 || empty_s1;
	assign adv_s1    = v_s1 && (!res_s1 || s2_free);
	assign req.ready = !v_s1 || !res_s1 || s2_free;

	assign is_digit = (char_s1 >= CH_ZERO) && (char_s1 <= CH_NINE);
	assign digit    = 4'(char_s1 - CH_ZERO);
	assign acc_cur  = hyphen_q ? lnum_q : fnum_q;
	assign acc_sum  = ACC_W'({acc_cur, 3'b000}) + ACC_W'({acc_cur, 1'b0}) + ACC_W'(digit);
	assign acc_ovf  = |acc_sum[ACC_W-1:VALUE_BITS];

	always_comb begin
		pfx_n    = pfx_q;
		err_n    = err_q;
		hyphen_n = hyphen_q;
		after_n  = after_q;
		fcnt_n   = fcnt_q;
		lcnt_n   = lcnt_q;
		fnum_n   = fnum_q;
		lnum_n   = lnum_q;
		fovf_n   = fovf_q;
		lovf_n   = lovf_q;
		if (err_q == ST_OK) begin
			if (pfx_q != PFX_LEN) begin
				if (char_s1 != lead_char(pfx_q)) begin
					err_n = ST_BAD;
				end
				pfx_n = pfx_q + 3'd1;
			end else begin
				after_n = 1'b1;
				if (is_digit) begin
					if (hyphen_q) begin
						if (lcnt_q < CNT_MAX) begin
							lcnt_n = lcnt_q + CNT_W'(1);
						end
						if (!lovf_q) begin
							if (acc_ovf) begin
								lovf_n = 1'b1;
							end else begin
								lnum_n = acc_sum[VALUE_BITS-1:0];
							end
						end
					end else begin
						if (fcnt_q < CNT_MAX) begin
							fcnt_n = fcnt_q + CNT_W'(1);
						end
						if (!fovf_q) begin
							if (acc_ovf) begin
								fovf_n = 1'b1;
							end else begin
								fnum_n = acc_sum[VALUE_BITS-1:0];
							end
						end
					end
				end else if (char_s1 == CH_HYPHEN) begin
					if (hyphen_q) begin
						err_n = ST_BAD;
					end else begin
						hyphen_n = 1'b1;
					end
				end else if (char_s1 == CH_COMMA && after_q) begin
					err_n = ST_UNSAT;
				end else begin
					err_n = ST_BAD;
				end
			end
		end
	end

	always_comb begin
		snap_n.empty      = empty_s1;
		snap_n.err        = err_n;
		snap_n.pfx_ok     = (pfx_n == PFX_LEN);
		snap_n.hyphen     = hyphen_n;
		snap_n.first_any  = (fcnt_n != '0);
		snap_n.first_long = (fcnt_n >= CNT_MAX);
		snap_n.first_ovf  = fovf_n;
		snap_n.first_num  = FIELD_W'(fnum_n);
		snap_n.last_any   = (lcnt_n != '0);
		snap_n.last_long  = (lcnt_n >= CNT_MAX);
		snap_n.last_ovf   = lovf_n;
		snap_n.last_num   = FIELD_W'(lnum_n);
		snap_n.size       = size_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (req.ready) begin
				v_s1 <= req.valid;
			end
			if (s2_free) begin
				v_s2 <= v_s1 && res_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			char_s1  <= req.char_code;
			last_s1  <= req.last_char;
			empty_s1 <= req.empty_field;
			size_s1  <= req.file_size;
		end
		if (adv_s1 && res_s1) begin
			snap_s2 <= snap_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pfx_q    <= '0;
			err_q    <= ST_OK;
			hyphen_q <= 1'b0;
			after_q  <= 1'b0;
			fcnt_q   <= '0;
			lcnt_q   <= '0;
			fnum_q   <= '0;
			lnum_q   <= '0;
			fovf_q   <= 1'b0;
			lovf_q   <= 1'b0;
		end else if (adv_s1) begin
			if (res_s1) begin
				pfx_q    <= '0;
				err_q    <= ST_OK;
				hyphen_q <= 1'b0;
				after_q  <= 1'b0;
				fcnt_q   <= '0;
				lcnt_q   <= '0;
				fnum_q   <= '0;
				lnum_q   <= '0;
				fovf_q   <= 1'b0;
				lovf_q   <= 1'b0;
			end else begin
				pfx_q    <= pfx_n;
				err_q    <= err_n;
				hyphen_q <= hyphen_n;
				after_q  <= after_n;
				fcnt_q   <= fcnt_n;
				lcnt_q   <= lcnt_n;
				fnum_q   <= fnum_n;
				lnum_q   <= lnum_n;
				fovf_q   <= fovf_n;
				lovf_q   <= lovf_n;
			end
		end
	end

	assign snap       = snap_s2;
	assign snap_valid = v_s2;
endmodule

// ===== rtl/brp_finish.sv =====
// ----------------------------------------------------------------------------
// HTTP byte-range parser range resolution
// Turns the end-of-field snapshot into status and clamped range.
// ----------------------------------------------------------------------------
module brp_finish (
	input  logic               clk,
	input  logic               arst_n,
	input  brp_pkg::brp_snap_t snap,
	input  logic               snap_valid,
	output logic               snap_ready,
	brp_out_if.source          rsp
);
	import brp_pkg::*;

	logic               vld_q, out_free;
	brp_status_t        st_n;
	logic [1:0]         status_q;
	logic [FIELD_W-1:0] lo_n, lo_q;
	logic [RANGE_W-1:0] hi_n, hi_q, top, up, first_ext, last_ext, size_ext;

	assign out_free   = !vld_q || rsp.ready;
	assign snap_ready = out_free;

	assign size_ext  = {1'b0, snap.size};
	assign first_ext = {1'b0, snap.first_num};
	assign last_ext  = {1'b0, snap.last_num};
	assign top       = size_ext - RANGE_W'(1);
	assign up        = snap.last_any ? last_ext : top;

	always_comb begin
		st_n = ST_OK;
		lo_n = '0;
		hi_n = '0;
		if (snap.empty) begin
			hi_n = top;
		end else if (snap.err != ST_OK) begin
			st_n = snap.err;
		end else if (!snap.pfx_ok || !snap.hyphen) begin
			st_n = ST_BAD;
		end else if (snap.first_long || snap.last_long) begin
			st_n = ST_LARGE;
		end else if (snap.first_any) begin
			if (snap.first_ovf || (snap.last_any && snap.last_ovf)) begin
				st_n = ST_BAD;
			end else if (first_ext > up || first_ext >= size_ext) begin
				st_n = ST_UNSAT;
			end else begin
				lo_n = snap.first_num;
				hi_n = (up < top) ? up : top;
			end
		end else if (!snap.last_any || snap.last_ovf) begin
			st_n = ST_BAD;
		end else begin
			lo_n = (snap.last_num > snap.size) ? '0 : snap.size - snap.last_num;
			hi_n = top;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (out_free) begin
			vld_q <= snap_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && snap_valid) begin
			status_q <= st_n;
			lo_q     <= lo_n;
			hi_q     <= hi_n;
		end
	end

	assign rsp.valid      = vld_q;
	assign rsp.status     = status_q;
	assign rsp.range_low  = lo_q;
	assign rsp.range_high = hi_q;
endmodule

// ===== rtl/http_byte_range_parser.sv =====
// A result passes from the input register through the snapshot to the output register.
// Throughput: one character per cycle unless stalled, set by the single scan stage
// and its shared multiply-by-ten accumulator; result stalls hold closing characters.
// Reset: arst_n clears all valid flags and scan state asynchronously.
// ----------------------------------------------------------------------------
// HTTP byte-range parser
// Parses a Range field one character per transaction into status and range.
// ----------------------------------------------------------------------------
`include "http_byte_range_parser_defines.svh"

module http_byte_range_parser #(
	parameter int LENGTH_LIMIT = 200,
	parameter int VALUE_BITS   = 63
) (
	input  logic      clk,
	input  logic      arst_n,
	brp_in_if.sink    req,
	brp_out_if.source rsp
);
	import brp_pkg::*;

	brp_snap_t snap;
	logic      snap_valid;
	logic      snap_ready;

	brp_parse #(
		.LENGTH_LIMIT(LENGTH_LIMIT),
		.VALUE_BITS  (VALUE_BITS)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.snap      (snap),
		.snap_valid(snap_valid),
		.snap_ready(snap_ready)
	);

	brp_finish u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.snap      (snap),
		.snap_valid(snap_valid),
		.snap_ready(snap_ready),
		.rsp       (rsp)
	);

	`BRP_ASSERT_NOW(a_err_zero_range, rsp.valid && rsp.status != ST_OK, rsp.range_low == '0 && rsp.range_high == '0, "error result with nonzero range")
	`BRP_ASSERT_NXT(a_snap_hold, snap_valid && !snap_ready, snap_valid && $stable(snap), "stalled snapshot changed")
	`BRP_ASSERT_NOW(a_out_stall, rsp.valid && !rsp.ready, !snap_ready, "snapshot taken while result stalled")
endmodule

// ===== dv/http_byte_range_parser_tb.sv =====
// ----------------------------------------------------------------------------
// HTTP byte-range parser testbench
// Drives Range field characters with random gaps and back-pressure, predicts
// status and byte range per field in a scoreboard class, checks each result.
// ----------------------------------------------------------------------------
module http_byte_range_parser_tb;
	import brp_pkg::*;

	localparam int          DIGIT_LIMIT = 200;
	localparam int          RANDOM_END  = 940;
	localparam int          HOLD_CYCLES = 400;
	localparam logic [63:0] VALUE_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef struct {
		brp_status_t        status;
		logic [FIELD_W-1:0] low;
		logic [RANGE_W-1:0] high;
	} range_t;

	class range_checker;
		int unsigned pfx_pos, after_cnt, first_cnt, last_cnt;
		brp_status_t pend;
		bit          hyphen, first_ovf, last_ovf;
		logic [63:0] first_num, last_num;
		range_t      expected_ranges[$];
		int          errors;
		string       lead = "bytes=";

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			pfx_pos = 0;
			pend = ST_OK;
			hyphen = 0;
			after_cnt = 0;
			first_cnt = 0;
			last_cnt = 0;
			first_num = '0;
			first_ovf = 0;
			last_num = '0;
			last_ovf = 0;
		endfunction

		function void add_digit(inout logic [63:0] num, inout bit ovf, inout int unsigned cnt,
				input logic [63:0] d);
			if (cnt < DIGIT_LIMIT)
				cnt++;
			if (!ovf) begin
				if (num > (VALUE_MAX - d) / 10)
					ovf = 1;
				else
					num = num * 10 + d;
			end
		endfunction

		function void scan_char(logic [CHAR_W-1:0] c);
			if (pend != ST_OK)
				return;
			if (pfx_pos < PFX_LEN) begin
				if (c != 8'(lead[pfx_pos]))
					pend = ST_BAD;
				pfx_pos++;
				return;
			end
			if (c >= CH_ZERO && c <= CH_NINE) begin
				if (hyphen)
					add_digit(last_num, last_ovf, last_cnt, 64'(c - CH_ZERO));
				else
					add_digit(first_num, first_ovf, first_cnt, 64'(c - CH_ZERO));
			end else if (c == CH_HYPHEN) begin
				if (hyphen)
					pend = ST_BAD;
				else
					hyphen = 1;
			end else if (c == CH_COMMA && after_cnt > 0) begin
				pend = ST_UNSAT;
			end else begin
				pend = ST_BAD;
			end
			if (after_cnt < 255)
				after_cnt++;
		endfunction

		function brp_status_t close_field(logic [FIELD_W-1:0] size, output logic [63:0] lo,
				output logic [63:0] hi);
			logic [63:0] sz, top, up;
			sz = {1'b0, size};
			top = sz - 64'd1;
			lo = '0;
			hi = '0;
			if (pend != ST_OK)
				return pend;
			if (pfx_pos < PFX_LEN || !hyphen)
				return ST_BAD;
			if (first_cnt >= DIGIT_LIMIT || last_cnt >= DIGIT_LIMIT)
				return ST_LARGE;
			if (first_cnt > 0) begin
				if (first_ovf || (last_cnt > 0 && last_ovf))
					return ST_BAD;
				up = (last_cnt > 0) ? last_num : top;
				if (first_num > up || first_num >= sz)
					return ST_UNSAT;
				lo = first_num;
				hi = (up < top) ? up : top;
				return ST_OK;
			end
			if (last_cnt == 0 || last_ovf)
				return ST_BAD;
			lo = (last_num > sz) ? 64'd0 : sz - last_num;
			hi = top;
			return ST_OK;
		endfunction

		function void note_input(logic [CHAR_W-1:0] c, bit last, bit empty,
				logic [FIELD_W-1:0] size);
			range_t      r;
			logic [63:0] lo, hi;
			if (empty) begin
				clear();
				r.status = ST_OK;
				r.low = '0;
				r.high = {1'b0, size} - 64'd1;
				expected_ranges.push_back(r);
				return;
			end
			scan_char(c);
			if (!last)
				return;
			r.status = close_field(size, lo, hi);
			r.low = lo[FIELD_W-1:0];
			r.high = hi;
			clear();
			expected_ranges.push_back(r);
		endfunction

		function void check_result(logic [1:0] st, logic [FIELD_W-1:0] lo,
				logic [RANGE_W-1:0] hi);
			range_t e;
			if (expected_ranges.size() == 0) begin
				$display("%0t: unexpected result status %0d low %0d high %0d", $time, st, lo, hi);
				errors++;
				return;
			end
			e = expected_ranges.pop_front();
			if (st !== e.status) begin
				$display("%0t: status expected %0d got %0d", $time, e.status, st);
				errors++;
			end
			if (lo !== e.low) begin
				$display("%0t: range_low expected %0d got %0d", $time, e.low, lo);
				errors++;
			end
			if (hi !== e.high) begin
				$display("%0t: range_high expected %0d got %0d", $time, e.high, hi);
				errors++;
			end
		endfunction

		function int outstanding();
			return expected_ranges.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	brp_in_if  req_if();
	brp_out_if rsp_if();

	http_byte_range_parser #(
		.LENGTH_LIMIT(DIGIT_LIMIT),
		.VALUE_BITS  (63)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.rsp   (rsp_if)
	);

	range_checker   rc = new();
	logic [CHAR_W-1:0] fld[$];
	int chars_sent  = 0;
	bit tx_burst    = 0;
	int holds_asked = 0;
	int holds_done  = 0;
	int rx_wait     = 0;
	int rx_run      = 0;
	int rx_pick;

	always #10 clk = ~clk;

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	// receive side: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready)
				rc.check_result(rsp_if.status, rsp_if.range_low, rsp_if.range_high);
			if (holds_asked != holds_done) begin
				holds_done <= holds_done + 1;
				rx_wait <= HOLD_CYCLES;
				rsp_if.ready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait <= rx_wait - 1;
				rsp_if.ready <= 1'b0;
			end else if (rx_run > 0) begin
				rx_run <= rx_run - 1;
				rsp_if.ready <= 1'b1;
			end else begin
				rx_pick = $urandom_range(0, 99);
				if (rx_pick < 10) begin
					rx_run <= $urandom_range(20, 80);
					rsp_if.ready <= 1'b1;
				end else if (rx_pick < 65) begin
					rsp_if.ready <= 1'b1;
				end else begin
					rx_wait <= idle_len();
					rsp_if.ready <= 1'b0;
				end
			end
		end
	end

	task automatic put_char(input logic [CHAR_W-1:0] c, input bit last, input bit empty,
			input logic [FIELD_W-1:0] size);
		int gap;
		req_if.valid <= 1'b1;
		req_if.char_code <= c;
		req_if.last_char <= last;
		req_if.empty_field <= empty;
		req_if.file_size <= size;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		rc.note_input(c, last, empty, size);
		chars_sent++;
		gap = tx_burst ? 0 : idle_len();
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_field(input logic [FIELD_W-1:0] size, input bit close);
		foreach (fld[i])
			put_char(fld[i], close && (i == fld.size() - 1), 1'b0, size);
		fld.delete();
	endtask

	task automatic drain();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (rc.outstanding() != 0)
			@(posedge clk);
	endtask

	function automatic void put_text(string s);
		foreach (s[i])
			fld.push_back(8'(s[i]));
	endfunction

	function automatic void put_number(logic [63:0] v);
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 3)) fld.push_back(CH_ZERO);
		put_text($sformatf("%0d", v));
	endfunction

	function automatic void put_digits(int n);
		fld.push_back(8'(CH_ZERO + $urandom_range(1, 9)));
		repeat (n - 1) fld.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
	endfunction

	function automatic logic [63:0] rand63();
		return ({$urandom, $urandom} & VALUE_MAX) >> $urandom_range(0, 62);
	endfunction

	function automatic logic [FIELD_W-1:0] pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return '0;
		if (r < 13)
			return FIELD_W'(1);
		if (r < 50)
			return FIELD_W'($urandom_range(2, 3000));
		if (r < 88)
			return FIELD_W'(rand63());
		return VALUE_MAX[FIELD_W-1:0];
	endfunction

	function automatic logic [63:0] pick_num(logic [FIELD_W-1:0] size);
		case ($urandom_range(0, 9))
			0:       return '0;
			1, 2:    return 64'($urandom_range(0, 5000));
			3:       return {1'b0, size - 1'b1};
			4:       return {1'b0, size};
			5:       return {1'b0, size} + 64'd1;
			6, 7:    return rand63();
			8:       return VALUE_MAX;
			default: return 64'($urandom_range(0, 50));
		endcase
	endfunction

	function automatic void put_range(logic [FIELD_W-1:0] size);
		logic [63:0] first;
		first = pick_num(size);
		case ($urandom_range(0, 2))
			0: begin
				put_number(first);
				fld.push_back(CH_HYPHEN);
				if ($urandom_range(0, 1))
					put_number(first + $urandom_range(0, 1000));
				else
					put_number(pick_num(size));
			end
			1: begin
				put_number(first);
				fld.push_back(CH_HYPHEN);
			end
			default: begin
				fld.push_back(CH_HYPHEN);
				put_number(first);
			end
		endcase
	endfunction

	initial begin
		logic [FIELD_W-1:0] size;
		int    r, n, field_no;
		string pfx;
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.char_code = '0;
		req_if.last_char = 1'b0;
		req_if.empty_field = 1'b0;
		req_if.file_size = '0;
		rsp_if.ready = 1'b0;
		pfx = "bytes=";
		field_no = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty field at size extremes, NUL in prefix, zero-size file,
		// suffix beyond the file, upper bound clamp
		put_char(8'h00, 1'b0, 1'b1, '0);
		put_char(8'hFF, 1'b1, 1'b1, VALUE_MAX[FIELD_W-1:0]);
		put_char(8'h00, 1'b1, 1'b0, FIELD_W'(100));
		put_text("bytes=0-");
		send_field('0, 1'b1);
		put_text("bytes=-5");
		send_field(FIELD_W'(3), 1'b1);
		put_text("bytes=2-9");
		send_field(FIELD_W'(5), 1'b1);

		while (chars_sent < RANDOM_END) begin
			field_no++;
			tx_burst = ($urandom_range(0, 6) == 0);
			size = pick_size();
			if (field_no == 16) begin
				holds_asked <= holds_asked + 1;
				repeat (40) put_char(8'($urandom), 1'($urandom), 1'b1, size);
			end
			if (field_no == 12)
				drain();
			r = $urandom_range(0, 99);
			if (field_no == 5 || field_no == 9 || r == 0) begin
				// numbers around the digit limit
				put_text("bytes=");
				if ($urandom_range(0, 1)) begin
					put_digits($urandom_range(DIGIT_LIMIT - 2, DIGIT_LIMIT + 2));
					fld.push_back(CH_HYPHEN);
					if ($urandom_range(0, 1))
						put_number(pick_num(size));
				end else begin
					fld.push_back(CH_HYPHEN);
					put_digits($urandom_range(DIGIT_LIMIT - 2, DIGIT_LIMIT + 2));
				end
			end else if (r < 56) begin
				put_text("bytes=");
				put_range(size);
			end else if (r < 61) begin
				// values of 19 to 22 digits, up to and past 63 bits
				put_text("bytes=");
				case ($urandom_range(0, 2))
					0: begin
						put_digits($urandom_range(19, 22));
						fld.push_back(CH_HYPHEN);
					end
					1: begin
						put_number(pick_num(size));
						fld.push_back(CH_HYPHEN);
						put_digits($urandom_range(19, 22));
					end
					default: begin
						fld.push_back(CH_HYPHEN);
						put_digits($urandom_range(19, 22));
					end
				endcase
			end else if (r < 66) begin
				// short or corrupted prefix
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++)
					fld.push_back(8'(pfx[i]));
				if (n == 6 || $urandom_range(0, 1))
					fld[$urandom_range(0, n - 1)] = 8'($urandom);
				if ($urandom_range(0, 1))
					put_range(size);
			end else if (r < 73) begin
				put_text("bytes=");
				put_range(size);
				case ($urandom_range(0, 4))
					0:       n = 0;
					1:       n = int'(CH_COMMA);
					2:       n = int'(CH_HYPHEN);
					3:       n = 32'h20;
					default: n = int'($urandom_range(0, 255));
				endcase
				fld.insert($urandom_range(6, fld.size()), 8'(n));
			end else if (r < 77) begin
				put_text("bytes=");
				if ($urandom_range(0, 1)) begin
					fld.push_back(CH_COMMA);
					put_range(size);
				end else begin
					put_range(size);
					fld.push_back(CH_COMMA);
					if ($urandom_range(0, 1))
						put_range(size);
				end
			end else if (r < 81) begin
				put_text("bytes=");
				case ($urandom_range(0, 2))
					0:       put_number(pick_num(size));
					1:       fld.push_back(CH_HYPHEN);
					default: ;
				endcase
			end else if (r < 87) begin
				put_char(8'($urandom), 1'($urandom), 1'b1, size);
			end else if (r < 92) begin
				// partial field cut off by an empty-field transaction
				put_text("bytes=");
				put_range(size);
				n = $urandom_range(1, fld.size());
				while (fld.size() > n)
					void'(fld.pop_back());
				send_field(size, 1'b0);
				put_char(8'($urandom), 1'b0, 1'b1, size);
			end else begin
				repeat ($urandom_range(1, 12)) fld.push_back(8'($urandom));
			end
			if (fld.size() != 0)
				send_field(size, 1'b1);
		end

		drain();
		repeat (10) @(posedge clk);
		if (rc.errors == 0 && rc.outstanding() == 0)
			$display("http_byte_range_parser_tb: done, clean");
		else
			$display("http_byte_range_parser_tb: done, errors");
		$finish;
	end

	initial begin
		#20000000;
		$display("http_byte_range_parser_tb: done, errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/brp_pkg.sv
rtl/brp_in_if.sv
rtl/brp_out_if.sv
rtl/brp_parse.sv
rtl/brp_finish.sv
rtl/http_byte_range_parser.sv
dv/http_byte_range_parser_tb.sv
